/* hdl/rqpf_pkg.sv */
// Shared types, codes and defaults for the ring queue with push-front.
package rqpf_pkg;

   localparam int DEPTH_DEFAULT     = 64;
   localparam int WORD_BITS_DEFAULT = 32;

   // Operation codes carried in the request kind field
   localparam logic [1:0] KIND_APPEND = 2'd0;
   localparam logic [1:0] KIND_INSERT = 2'd1;
   localparam logic [1:0] KIND_REMOVE = 2'd2;

   // Status codes returned with every response
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [31:0] removed_value;
      logic [1:0]  status;
      logic [6:0]  count;
      logic        is_empty;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

endpackage

/* hdl/rqpf_ram.sv */
// Generic single-clock RAM, one write port and one registered read port.
module rqpf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/ring_queue_with_push_front.sv */
// Top level: circular word queue with tail append, head insert and head remove.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------------
//   req     | in        | req_valid / req_stall  | kind, value
//   rsp     | out       | rsp_valid / rsp_stall  | removed_value, status, count, is_empty
//
// Append, insert and any failed or no-op request: response in the next cycle, one
// transfer per clock unless stalled. Successful remove: slot RAM read, then response register.
// Synchronous reset empties the queue (head and count to zero); the slot RAM is
// not cleared since every slot is written before it is read.
// A waiting response register that is stalled stalls the request side as well;
// a response that is being taken frees the register in the same cycle.
module ring_queue_with_push_front
   import rqpf_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int AW   = $clog2(DEPTH);      // slot address width
   localparam int CW   = $clog2(DEPTH + 1);  // count width, holds DEPTH itself
   localparam int SW   = AW + 1;             // head + count before wrap
   localparam int OUTW = (WORD_BITS < 32) ? WORD_BITS : 32;

   state_type       state_ff, state_in;
   logic [AW-1:0]   head_ff, head_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;

   logic                 accept;
   logic                 full, empty;
   logic [SW-1:0]        tail_sum;
   logic [AW-1:0]        tail_addr, head_dec, head_inc;

   logic                 wr_en, rd_en;
   logic [AW-1:0]        wr_addr;
   logic [WORD_BITS-1:0] wr_data, rd_data;

   rqpf_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   // Busy while a remove waits on the RAM, or while the output holds a stalled result
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);

   // Tail = (head + count) mod DEPTH; sum stays below 2*DEPTH
   assign tail_sum  = SW'(head_ff) + SW'(count_ff);
   assign tail_addr = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
   assign head_dec  = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
   assign head_inc  = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);

   assign wr_data = WORD_BITS'(req_data.value);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = tail_addr;
      rd_en        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_in.removed_value = '0;
               rsp_in.status        = STATUS_OK;
               rsp_valid_in         = 1'b1;
               case (req_data.kind)
                  KIND_APPEND: begin
                     if (full) begin
                        rsp_in.status = STATUS_OVERFLOW;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  KIND_INSERT: begin
                     if (full) begin
                        rsp_in.status = STATUS_OVERFLOW;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = head_dec;
                        head_in  = head_dec;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  KIND_REMOVE: begin
                     if (empty) begin
                        rsp_in.status = STATUS_UNDERFLOW;
                     end else begin
                        // word arrives next cycle; hold the response until then
                        rd_en        = 1'b1;
                        head_in      = head_inc;
                        count_in     = count_ff - CW'(1);
                        rsp_valid_in = 1'b0;
                        state_in     = ST_READ;
                     end
                  end
                  default: begin
                     // undefined kind: no change, ok status
                  end
               endcase
               rsp_in.count    = 7'(count_in);
               rsp_in.is_empty = (count_in == '0);
            end
         end
         ST_READ: begin
            rsp_in.removed_value = 32'(rd_data[OUTW-1:0]);
            rsp_valid_in         = 1'b1;
            state_in             = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* verif/tb.sv */
// Self-checking testbench for the ring queue with head insert: random traffic, scoreboard.
module tb;
   import rqpf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Kind code that the block treats as a no-op
   localparam logic [1:0] KIND_NOP = 2'd3;

   localparam int QDEPTH       = DEPTH_DEFAULT;
   localparam int RANDOM_OPS   = 850;
   localparam int MAX_REPORTS  = 10;
   localparam int CYCLE_LIMIT  = 400000;
   // Cycles in which neither side idles or stalls
   localparam int QUIET_START  = 800;
   localparam int QUIET_STOP   = 1800;
   localparam int IDLE_PERCENT = 12;
   localparam int TAIL_CYCLES  = 16;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   ring_queue_with_push_front dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Queue predictor: own copy of slots, head and occupancy
   // ------------------------------------------------------------------
   logic [31:0] model_slots [QDEPTH];
   int          model_head = 0;
   int          model_fill = 0;

   // Applies one request to the predicted queue and returns the response it must produce.
   function automatic rsp_type apply_queue_op(req_type op);
      rsp_type r;
      r        = '0;
      r.status = STATUS_OK;
      case (op.kind)
         KIND_APPEND, KIND_INSERT: begin
            if (model_fill == QDEPTH) begin
               r.status = STATUS_OVERFLOW;   // full: append or insert dropped
            end else if (op.kind == KIND_APPEND) begin
               model_slots[(model_head + model_fill) % QDEPTH] = op.value;
               model_fill++;
            end else begin
               // head steps back one slot, wrapping below zero
               model_head = (model_head == 0) ? QDEPTH - 1 : model_head - 1;
               model_slots[model_head] = op.value;
               model_fill++;
            end
         end
         KIND_REMOVE: begin
            if (model_fill == 0) begin
               r.status = STATUS_UNDERFLOW;  // empty: nothing taken
            end else begin
               r.removed_value = model_slots[model_head];
               model_head      = (model_head + 1) % QDEPTH;
               model_fill--;
            end
         end
         default: ;                          // no-op kind leaves the queue alone
      endcase
      r.count    = 7'(model_fill);
      r.is_empty = (model_fill == 0);
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Shared bookkeeping
   // ------------------------------------------------------------------
   req_type pending_ops [$];     // requests waiting to be driven
   int      drain_marks [$];     // request counts at which the sender waits for all responses
   rsp_type expected_rsps [$];   // predicted responses, oldest first
   int      ops_sent    = 0;     // request transfers so far
   int      rsps_taken  = 0;     // response transfers so far
   int      fault_count = 0;
   int      cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, expected_rsps.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Random idle draw, suppressed inside the quiet window
   function automatic bit idle_draw();
      if (cycle_count >= QUIET_START && cycle_count < QUIET_STOP) return 1'b0;
      return $urandom_range(0, 99) < IDLE_PERCENT;
   endfunction

   // ------------------------------------------------------------------
   // Request driver. A transfer at this edge is predicted here; the next
   // request is only presented once the current one has been taken, so a
   // stalled payload never moves.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      int  sent_now;
      bit  hold;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         sent_now = ops_sent;
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(apply_queue_op(req_data));
            sent_now = ops_sent + 1;
            ops_sent <= sent_now;
         end
         if (!req_valid || !req_stall) begin
            // pause point: hold off until every response so far has come back
            hold = 1'b0;
            if (drain_marks.size() > 0 && sent_now == drain_marks[0]) begin
               if (rsps_taken == sent_now) drain_marks.pop_front();
               else hold = 1'b1;
            end
            if (pending_ops.size() > 0 && !hold && !idle_draw()) begin
               req_valid <= 1'b1;
               req_data  <= pending_ops.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Response monitor and scoreboard; also drives the random stall
   // ------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsps_taken <= rsps_taken + 1;
            if (expected_rsps.size() == 0) begin
               fault_count++;
               if (fault_count <= MAX_REPORTS)
                  $display("%0t: unexpected response value=%h status=%0d count=%0d empty=%0b",
                           $realtime, rsp_data.removed_value, rsp_data.status,
                           rsp_data.count, rsp_data.is_empty);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.removed_value !== want.removed_value ||
                   rsp_data.status        !== want.status ||
                   rsp_data.count         !== want.count ||
                   rsp_data.is_empty      !== want.is_empty) begin
                  fault_count++;
                  if (fault_count <= MAX_REPORTS) begin
                     $display("%0t: response %0d mismatch (expected/actual): value %h/%h",
                              $realtime, rsps_taken, want.removed_value,
                              rsp_data.removed_value);
                     $display("   status %0d/%0d count %0d/%0d empty %0b/%0b",
                              want.status, rsp_data.status, want.count, rsp_data.count,
                              want.is_empty, rsp_data.is_empty);
                  end
               end
            end
         end
         rsp_stall <= idle_draw();
      end
   end

   // ------------------------------------------------------------------
   // Stimulus: directed corners, then random fill / drain / mixed phases
   // ------------------------------------------------------------------
   int gen_fill   = 0;   // occupancy as seen by the generator, to steer phases
   int real_ops   = 0;   // requests that touch the queue (no-ops excluded)

   task automatic queue_op(input logic [1:0] kind, input logic [31:0] value);
      req_type op;
      op.kind  = kind;
      op.value = value;
      pending_ops.push_back(op);
      if (kind != KIND_NOP) real_ops++;
      if ((kind == KIND_APPEND || kind == KIND_INSERT) && gen_fill < QDEPTH) gen_fill++;
      if (kind == KIND_REMOVE && gen_fill > 0) gen_fill--;
   endtask

   function automatic logic [1:0] random_insert_kind();
      return $urandom_range(0, 1) ? KIND_APPEND : KIND_INSERT;
   endfunction

   initial begin
      // directed: underflow and no-op on an empty queue, word extremes,
      // head insert wrapping below slot zero, then draining in order
      queue_op(KIND_REMOVE, 32'h0000_0000);
      queue_op(KIND_NOP,    32'hFFFF_FFFF);
      queue_op(KIND_APPEND, 32'h0000_0000);
      queue_op(KIND_APPEND, 32'hFFFF_FFFF);
      queue_op(KIND_INSERT, 32'h8000_0001);
      queue_op(KIND_INSERT, 32'h7FFF_FFFE);
      queue_op(KIND_NOP,    32'h1234_5678);
      queue_op(KIND_REMOVE, 32'hFFFF_FFFF);
      queue_op(KIND_REMOVE, 32'h0000_0000);
      queue_op(KIND_REMOVE, 32'h0000_0000);
      queue_op(KIND_REMOVE, 32'h0000_0000);
      queue_op(KIND_REMOVE, 32'h0000_0000);
      queue_op(KIND_APPEND, 32'hA5A5_A5A5);
      queue_op(KIND_INSERT, 32'h5A5A_5A5A);
      queue_op(KIND_REMOVE, 32'h0000_0000);
      queue_op(KIND_APPEND, 32'h0000_0001);
      queue_op(KIND_REMOVE, 32'h0000_0000);
      queue_op(KIND_REMOVE, 32'h0000_0000);
      drain_marks.push_back(pending_ops.size());

      while (real_ops < RANDOM_OPS) begin
         case ($urandom_range(0, 2))
            0: begin
               // fill to the brim, then push past it for overflow
               while (gen_fill < QDEPTH)
                  queue_op(($urandom_range(0, 9) == 0) ? KIND_REMOVE : random_insert_kind(),
                           $urandom);
               repeat ($urandom_range(1, 3)) queue_op(random_insert_kind(), $urandom);
            end
            1: begin
               // drain to empty, then remove past it for underflow
               while (gen_fill > 0)
                  queue_op(($urandom_range(0, 9) == 0) ? random_insert_kind() : KIND_REMOVE,
                           $urandom);
               repeat ($urandom_range(1, 3)) queue_op(KIND_REMOVE, $urandom);
            end
            default: begin
               repeat ($urandom_range(20, 60))
                  queue_op(($urandom_range(0, 19) == 0) ? KIND_NOP
                                                        : 2'($urandom_range(0, 2)),
                           $urandom);
            end
         endcase
         if ($urandom_range(0, 3) == 0) drain_marks.push_back(pending_ops.size());
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // all requests out, all responses back, then a few spare cycles
      do @(posedge clock);
      while (pending_ops.size() != 0 || req_valid || rsps_taken != ops_sent);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (expected_rsps.size() != 0) begin
         fault_count++;
         $display("%0d expected responses never arrived", expected_rsps.size());
      end
      if (fault_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/rqpf_pkg.sv
hdl/rqpf_ram.sv
hdl/ring_queue_with_push_front.sv
verif/tb.sv
